### sv/vfrc_pkg.sv
// ----------------------------------------------------------------------------
// vfrc_pkg: shared types and constants for the frame receiver
// Holds the parser phase codes, event codes, register indexes and the
// reflected CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package vfrc_pkg;

   // Number of leading payload bytes kept for the status fields
   localparam int STATUS_FIELD_BYTES = 5;

   // Reflected CRC-8 polynomial
   localparam logic [7:0] CRC_POLY = 8'hB2;

   // Reset values of the configuration registers
   localparam logic [7:0] HEADER_RESET      = 8'h00;
   localparam logic [7:0] MAX_LEN_RESET     = 8'd64;
   localparam logic [7:0] STATUS_TYPE_RESET = 8'h00;

   // Parser phase
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_TYPE    = 3'd1,
      PH_LEN     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CHECK   = 3'd4
   } phase_type;

   // Frame event codes
   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_GOOD     = 2'd1,
      EV_BAD_CRC  = 2'd2,
      EV_LEN_DROP = 2'd3
   } event_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_HEADER      = 2'd0,
      CSR_MAX_LEN     = 2'd1,
      CSR_STATUS_TYPE = 2'd2
   } csr_index_type;

   // Fold one byte into a reflected CRC-8
   function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage : vfrc_pkg

`default_nettype wire

### sv/vtx_frame_receiver_crc8.sv
// ----------------------------------------------------------------------------
// vtx_frame_receiver_crc8: length-prefixed frame parser with CRC-8 check
// Hunts for a header byte, reads type, length, payload and check byte, and
// loads the device status registers from a good status response.
// ----------------------------------------------------------------------------
// The result item for an accepted byte is registered and valid in the cycle after it.
// Throughput: one byte per cycle; the CRC byte update and the phase step
// are a single combinational pass into the parser and result registers.
// Input stalls only while a result is held and the result side is not ready.
// Reset (synchronous): parser to header hunt, device channel and power to -1,
// configuration to defaults, output channel empty.
`default_nettype none

module vtx_frame_receiver_crc8
   import vfrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata,
   // received bytes
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   // result items
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [7:0] frame_kind, [15:8] frame_payload_len,
                                         // [16] status_updated, [25:17] device_channel,
                                         // [41:26] device_freq, [51:42] device_power,
                                         // [59:52] device_mode, [63:60] zero
   output      logic [1:0]  rsp_tuser    // [1:0] frame_event
);

   // Configuration registers
   logic [7:0] header_ff;
   logic [7:0] max_len_ff;
   logic [7:0] status_type_ff;

   // Parser state
   phase_type  phase_ff,  phase_in;
   logic [7:0] left_ff,   left_in;
   logic [7:0] pos_ff,    pos_in;
   logic [7:0] crc_ff,    crc_in;
   logic [7:0] kind_ff,   kind_in;
   logic [7:0] len_ff,    len_in;
   logic [7:0] stat_ff [STATUS_FIELD_BYTES];
   logic [7:0] stat_in [STATUS_FIELD_BYTES];

   // Device status registers
   logic [8:0]  chan_ff,  chan_in;
   logic [15:0] freq_ff,  freq_in;
   logic [9:0]  power_ff, power_in;
   logic [7:0]  mode_ff,  mode_in;

   // Result register
   logic        out_valid_ff;
   event_type   ev_ff,   ev_in;
   logic [7:0]  okind_ff, okind_in;
   logic [7:0]  olen_ff,  olen_in;
   logic        upd_ff,   upd_in;

   logic       accept;
   logic [7:0] b;
   logic [7:0] crc_step;
   logic [7:0] left_dec;

   assign b          = req_tdata;
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign crc_step   = crc8_add(crc_ff, b);
   assign left_dec   = (left_ff != 8'd0) ? (left_ff - 8'd1) : 8'd0;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff      <= HEADER_RESET;
         max_len_ff     <= MAX_LEN_RESET;
         status_type_ff <= STATUS_TYPE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_HEADER:      header_ff      <= csr_wdata;
            CSR_MAX_LEN:     max_len_ff     <= csr_wdata;
            CSR_STATUS_TYPE: status_type_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // Advance the parser by one byte
   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      kind_in  = kind_ff;
      len_in   = len_ff;
      for (int i = 0; i < STATUS_FIELD_BYTES; i++) begin
         stat_in[i] = stat_ff[i];
      end
      chan_in  = chan_ff;
      freq_in  = freq_ff;
      power_in = power_ff;
      mode_in  = mode_ff;
      ev_in    = EV_NONE;
      okind_in = 8'd0;
      olen_in  = 8'd0;
      upd_in   = 1'b0;

      unique case (phase_ff)
         PH_TYPE: begin
            kind_in  = b;
            crc_in   = crc_step;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            if (b > max_len_ff) begin
               ev_in    = EV_LEN_DROP;
               okind_in = kind_ff;
               olen_in  = b;
               phase_in = PH_HUNT;
            end else begin
               len_in   = b;
               left_in  = b;
               pos_in   = 8'd0;
               crc_in   = crc_step;
               phase_in = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            // keep only the leading status bytes
            for (int i = 0; i < STATUS_FIELD_BYTES; i++) begin
               if (pos_ff == 8'(i)) stat_in[i] = b;
            end
            if (pos_ff != 8'hFF) pos_in = pos_ff + 8'd1;
            crc_in  = crc_step;
            left_in = left_dec;
            if (left_dec == 8'd0) phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            okind_in = kind_ff;
            olen_in  = len_ff;
            if (b == crc_ff) begin
               ev_in = EV_GOOD;
               if (kind_ff == status_type_ff) begin
                  upd_in   = 1'b1;
                  chan_in  = {1'b0, stat_ff[0]};
                  freq_in  = {stat_ff[1], stat_ff[2]};
                  power_in = {2'b00, stat_ff[3]} + 10'd1;
                  mode_in  = stat_ff[4];
               end
            end else begin
               ev_in = EV_BAD_CRC;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            // header hunt, and any unused phase code
            if (b == header_ff) begin
               for (int i = 0; i < STATUS_FIELD_BYTES; i++) begin
                  stat_in[i] = 8'd0;
               end
               crc_in   = crc8_add(8'd0, b);
               kind_in  = 8'd0;
               len_in   = 8'd0;
               left_in  = 8'd0;
               pos_in   = 8'd0;
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         left_ff      <= 8'd0;
         pos_ff       <= 8'd0;
         crc_ff       <= 8'd0;
         kind_ff      <= 8'd0;
         len_ff       <= 8'd0;
         chan_ff      <= '1;
         freq_ff      <= 16'd0;
         power_ff     <= '1;
         mode_ff      <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            pos_ff   <= pos_in;
            crc_ff   <= crc_in;
            kind_ff  <= kind_in;
            len_ff   <= len_in;
            chan_ff  <= chan_in;
            freq_ff  <= freq_in;
            power_ff <= power_in;
            mode_ff  <= mode_in;
         end
         if (accept) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   // Load payload status bytes and result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < STATUS_FIELD_BYTES; i++) begin
            stat_ff[i] <= stat_in[i];
         end
         ev_ff    <= ev_in;
         okind_ff <= okind_in;
         olen_ff  <= olen_in;
         upd_ff   <= upd_in;
      end
   end

   // Drive the result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = ev_ff;
   assign rsp_tdata  = {4'b0000, mode_ff, power_ff, freq_ff, chan_ff,
                        upd_ff, olen_ff, okind_ff};

endmodule : vtx_frame_receiver_crc8

`default_nettype wire

### sv/vfrc_checker.sv
// ----------------------------------------------------------------------------
// vfrc_checker: port-level checks for the frame receiver
// Watches the result channel for handshake and frame event consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module vfrc_checker
   import vfrc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // Every accepted byte yields a result item next cycle
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item produced no result");

   // A status update comes only with a good frame
   a_update_good: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tuser == EV_GOOD)
      else $error("status update without good frame");

   // No event carries no frame kind, length or update
   a_none_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_NONE |-> rsp_tdata[16:0] == 17'd0)
      else $error("frame fields set without frame event");

   // Drop output after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule : vfrc_checker

bind vtx_frame_receiver_crc8 vfrc_checker u_vfrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
